>>> rtl/core/cebs_pkg.sv
// ----------------------------------------------------------------------------
// cebs_pkg
// Shared constants for the clamped encoder bank stepper: field widths,
// bank size and stream packing offsets.
// ----------------------------------------------------------------------------
package cebs_pkg;

   localparam int ENC_COUNT              = 16;
   localparam int ENC_W                  = 4;
   localparam int ENCODERS_PER_BANK_DEF  = 8;
   localparam int VALUE_WIDTH_DEF        = 32;
   localparam int FIELD_W                = 32;
   localparam int LANES                  = 8;

   // request tdata packing, lowest bit first
   localparam int REQ_BANK_LSB  = 0;
   localparam int REQ_PINS_LSB  = 1;
   localparam int REQ_FLAGS_LSB = 17;
   localparam int REQ_INDEX_LSB = 25;
   localparam int REQ_STEP_LSB  = 29;
   localparam int REQ_MIN_LSB   = 61;
   localparam int REQ_MAX_LSB   = 93;
   localparam int REQ_START_LSB = 125;
   localparam int REQ_DATA_W    = 160;

   localparam int RSP_DATA_W    = 40;
   localparam int RSP_USER_W    = 2;

   localparam logic OP_EVENT = 1'b0;
   localparam logic OP_LOAD  = 1'b1;

endpackage

>>> rtl/core/clamped_encoder_bank_stepper_unit.sv
// A load writes the addressed encoder entry while the unit is idle. An event with n
// flagged encoders steps each one through an add step, then a clamp and write-back
// step, in one shared adder/compare unit; each result is registered in its clamp step.
// A new request is taken only in idle: after all n flagged encoders (n <=
// ENCODERS_PER_BANK) are done, and the clamp step waits while the result side stalls.
// Reset clears all encoder entries and control.
// ----------------------------------------------------------------------------
// clamped_encoder_bank_stepper_unit
// Sixteen x2 quadrature encoder values with per-encoder step and clamp bounds.
// ----------------------------------------------------------------------------
module clamped_encoder_bank_stepper_unit #(
   parameter int ENCODERS_PER_BANK = cebs_pkg::ENCODERS_PER_BANK_DEF,
   parameter int VALUE_WIDTH       = cebs_pkg::VALUE_WIDTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // bank, pin_levels[16], change_flags[8], entry_index[4], entry_step,
   // entry_min, entry_max, entry_start, zero pad
   input  logic [cebs_pkg::REQ_DATA_W-1:0] req_tdata,
   // operation
   input  logic [0:0]                      req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // encoder_number[4], new_value[32], zero pad
   output logic [cebs_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // moved_up, hit_bound
   output logic [cebs_pkg::RSP_USER_W-1:0] rsp_tuser,
   output logic                            rsp_tlast
);

   localparam int VW    = VALUE_WIDTH;
   localparam int EPB   = ENCODERS_PER_BANK;
   localparam int J_W   = (EPB > 1) ? $clog2(EPB) : 1;
   localparam int ENC_W = cebs_pkg::ENC_W;
   localparam int FW    = cebs_pkg::FIELD_W;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_ADD   = 2'd1;
   localparam logic [1:0] ST_CLAMP = 2'd2;

   logic signed [VW-1:0] value_ff [cebs_pkg::ENC_COUNT];
   logic signed [VW-1:0] step_ff  [cebs_pkg::ENC_COUNT];
   logic signed [VW-1:0] low_ff   [cebs_pkg::ENC_COUNT];
   logic signed [VW-1:0] high_ff  [cebs_pkg::ENC_COUNT];

   logic [1:0]            state_ff, state_in;
   logic [EPB-1:0]        flags_ff, flags_in;
   logic [EPB-1:0]        a_lvl_ff, a_lvl_in;
   logic [EPB-1:0]        b_lvl_ff, b_lvl_in;
   logic                  bank_ff, bank_in;
   logic signed [VW:0]    sum_ff, sum_in;
   logic signed [VW-1:0]  bound_ff, bound_in;
   logic                  up_ff, up_in;
   logic [ENC_W-1:0]      enc_ff, enc_in;
   logic [J_W-1:0]        lane_ff, lane_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [ENC_W-1:0]      rsp_enc_ff, rsp_enc_in;
   logic [FW-1:0]         rsp_value_ff, rsp_value_in;
   logic                  rsp_up_ff, rsp_up_in;
   logic                  rsp_hit_ff, rsp_hit_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic                  req_fire;
   logic                  load_fire;
   logic                  clamp_fire;
   logic [J_W-1:0]        lane_sel;
   logic [ENC_W-1:0]      enc_sel;
   logic                  up_sel;
   logic [EPB-1:0]        req_flags;
   logic signed [VW-1:0]  val_rd, step_rd;
   logic signed [VW:0]    val_x, step_x, bound_x;
   logic                  bound_hit;
   logic                  sat_hit;
   logic signed [VW-1:0]  result;
   logic [EPB-1:0]        flags_left;

   function automatic logic [J_W-1:0] lowest_set(input logic [EPB-1:0] f);
      logic [J_W-1:0] idx;
      idx = '0;
      for (int i = EPB - 1; i >= 0; i--) begin
         if (f[i]) begin
            idx = J_W'(i);
         end
      end
      return idx;
   endfunction

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign load_fire  = req_fire && (req_tuser[0] == cebs_pkg::OP_LOAD);
   assign req_flags  = req_tdata[cebs_pkg::REQ_FLAGS_LSB +: EPB];

   // lane pick and encoder number for the add step
   assign lane_sel = lowest_set(flags_ff);
   assign enc_sel  = (bank_ff ? ENC_W'(EPB) : '0) + ENC_W'(lane_sel);
   assign up_sel   = (a_lvl_ff[lane_sel] == b_lvl_ff[lane_sel]);
   assign val_rd   = value_ff[enc_sel];
   assign step_rd  = step_ff[enc_sel];
   assign val_x    = (VW+1)'(val_rd);
   assign step_x   = (VW+1)'(step_rd);

   // clamp step: one-sided bound, then saturate a sum that left the range
   assign bound_x   = (VW+1)'(bound_ff);
   assign bound_hit = up_ff ? (sum_ff > bound_x) : (sum_ff < bound_x);
   assign sat_hit   = (sum_ff[VW] != sum_ff[VW-1]);
   always_comb begin
      if (bound_hit) begin
         result = bound_ff;
      end else if (sat_hit) begin
         result = sum_ff[VW] ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}};
      end else begin
         result = sum_ff[VW-1:0];
      end
   end

   assign clamp_fire = (state_ff == ST_CLAMP) && (!rsp_valid_ff || rsp_tready);
   assign flags_left = flags_ff & ~(EPB'(1) << lane_ff);

   always_comb begin
      state_in     = state_ff;
      flags_in     = flags_ff;
      a_lvl_in     = a_lvl_ff;
      b_lvl_in     = b_lvl_ff;
      bank_in      = bank_ff;
      sum_in       = sum_ff;
      bound_in     = bound_ff;
      up_in        = up_ff;
      enc_in       = enc_ff;
      lane_in      = lane_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_enc_in   = rsp_enc_ff;
      rsp_value_in = rsp_value_ff;
      rsp_up_in    = rsp_up_ff;
      rsp_hit_in   = rsp_hit_ff;
      rsp_last_in  = rsp_last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire && (req_tuser[0] == cebs_pkg::OP_EVENT)) begin
               flags_in = req_flags;
               a_lvl_in = req_tdata[cebs_pkg::REQ_PINS_LSB +: EPB];
               b_lvl_in = req_tdata[cebs_pkg::REQ_PINS_LSB + cebs_pkg::LANES +: EPB];
               bank_in  = req_tdata[cebs_pkg::REQ_BANK_LSB];
               if (req_flags != '0) begin
                  state_in = ST_ADD;
               end
            end
         end
         ST_ADD: begin
            up_in    = up_sel;
            enc_in   = enc_sel;
            lane_in  = lane_sel;
            sum_in   = up_sel ? (val_x + step_x) : (val_x - step_x);
            bound_in = up_sel ? high_ff[enc_sel] : low_ff[enc_sel];
            state_in = ST_CLAMP;
         end
         ST_CLAMP: begin
            if (clamp_fire) begin
               rsp_valid_in = 1'b1;
               rsp_enc_in   = enc_ff;
               rsp_value_in = FW'(result);
               rsp_up_in    = up_ff;
               rsp_hit_in   = bound_hit || sat_hit;
               rsp_last_in  = (flags_left == '0);
               flags_in     = flags_left;
               state_in     = (flags_left == '0) ? ST_IDLE : ST_ADD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         flags_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         flags_ff     <= flags_in;
      end
   end

   always_ff @(posedge clock) begin
      a_lvl_ff     <= a_lvl_in;
      b_lvl_ff     <= b_lvl_in;
      bank_ff      <= bank_in;
      sum_ff       <= sum_in;
      bound_ff     <= bound_in;
      up_ff        <= up_in;
      enc_ff       <= enc_in;
      lane_ff      <= lane_in;
      rsp_enc_ff   <= rsp_enc_in;
      rsp_value_ff <= rsp_value_in;
      rsp_up_ff    <= rsp_up_in;
      rsp_hit_ff   <= rsp_hit_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // encoder entries; loaded fields are sign-extended or cut to VW
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < cebs_pkg::ENC_COUNT; k++) begin
            value_ff[k] <= '0;
            step_ff[k]  <= '0;
            low_ff[k]   <= '0;
            high_ff[k]  <= '0;
         end
      end else if (load_fire) begin
         step_ff[req_tdata[cebs_pkg::REQ_INDEX_LSB +: ENC_W]] <=
            VW'($signed(req_tdata[cebs_pkg::REQ_STEP_LSB +: FW]));
         low_ff[req_tdata[cebs_pkg::REQ_INDEX_LSB +: ENC_W]] <=
            VW'($signed(req_tdata[cebs_pkg::REQ_MIN_LSB +: FW]));
         high_ff[req_tdata[cebs_pkg::REQ_INDEX_LSB +: ENC_W]] <=
            VW'($signed(req_tdata[cebs_pkg::REQ_MAX_LSB +: FW]));
         value_ff[req_tdata[cebs_pkg::REQ_INDEX_LSB +: ENC_W]] <=
            VW'($signed(req_tdata[cebs_pkg::REQ_START_LSB +: FW]));
      end else if (clamp_fire) begin
         value_ff[enc_ff] <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(cebs_pkg::RSP_DATA_W - ENC_W - FW){1'b0}}, rsp_value_ff, rsp_enc_ff};
   assign rsp_tuser  = {rsp_hit_ff, rsp_up_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule
